[rtl/core/ottq_pkg.sv]
// Package for the ordered timer queue: field widths, opcodes, result kinds.
`timescale 1ns / 1ps
`default_nettype none
package ottq_pkg;
  localparam int DEPTH_DEF   = 16;
  localparam int PAYLOAD_DEF = 32;

  localparam int TIME_W  = 32;
  localparam int HDL_W   = 4;
  localparam int PAY_W   = 32;
  localparam int DELAY_W = 33;
  localparam int OP_W    = 2;
  localparam int KIND_W  = 2;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 72;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_FIRE   = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd3;

  localparam logic [KIND_W-1:0] KIND_FIRED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELAY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FULL  = 2'd2;
endpackage
`default_nettype wire

[rtl/core/ottq_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module ottq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire                      re,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

[rtl/core/ordered_timer_queue_unit.sv]
// Top level of the ordered timer queue: sorted timer list kept in one RAM.
//
// channel | dir | fields
// in_*    | in  | tuser: opcode; tdata: current_time, timer_handle, delay_ticks, signal_payload
// out_*   | out | tuser: result_kind; tdata: fired_handle, fired_payload, next_delay; tlast
//
// One request at a time. Each step of a scan or shift is a RAM read state followed by a
// write or check state. A remove runs the handle scan and close; an add runs the same,
// then the full check, the insert scan and the gap opening; a query reads the head; a fire
// reads the head and closes the gap for each due timer until the head is not due.
// Synchronous active-low reset empties the queue; RAM contents need no clearing.
// A result waits in the output register; a new request is taken meanwhile, and
// any result it produces waits until the output register is free.
`timescale 1ns / 1ps
`default_nettype none
module ordered_timer_queue_unit #(
  parameter int DEPTH         = ottq_pkg::DEPTH_DEF,
  parameter int PAYLOAD_WIDTH = ottq_pkg::PAYLOAD_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // [1:0] opcode
  input  wire  [ottq_pkg::OP_W-1:0]        in_tuser,
  // [31:0] current_time, [35:32] timer_handle, [67:36] delay_ticks, [99:68] signal_payload
  input  wire  [ottq_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // [1:0] result_kind
  output logic [ottq_pkg::KIND_W-1:0]      out_tuser,
  // [3:0] fired_handle, [35:4] fired_payload, [68:36] next_delay
  output logic [ottq_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                             out_tlast
);
  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int PW  = PAYLOAD_WIDTH;
  localparam int TW  = ottq_pkg::TIME_W;
  localparam int HW  = ottq_pkg::HDL_W;
  localparam int RW  = TW + PW + HW;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RSCAN = 5'd1;
  localparam logic [4:0] S_RCHK  = 5'd2;
  localparam logic [4:0] S_DSHR  = 5'd3;
  localparam logic [4:0] S_DSHW  = 5'd4;
  localparam logic [4:0] S_AFULL = 5'd5;
  localparam logic [4:0] S_ASCAN = 5'd6;
  localparam logic [4:0] S_ACHK  = 5'd7;
  localparam logic [4:0] S_ISHR  = 5'd8;
  localparam logic [4:0] S_ISHW  = 5'd9;
  localparam logic [4:0] S_FRD   = 5'd10;
  localparam logic [4:0] S_FCHK  = 5'd11;
  localparam logic [4:0] S_FOUT  = 5'd12;
  localparam logic [4:0] S_QRD   = 5'd13;
  localparam logic [4:0] S_QCHK  = 5'd14;
  localparam logic [4:0] S_QOUT  = 5'd15;

  // control registers
  logic [4:0]  state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic        pend_r, pend_nxt;
  logic        fires_r, fires_nxt;
  logic        ovalid_r, ovalid_nxt;

  // request and data registers
  logic [ottq_pkg::OP_W-1:0] op_r, op_nxt;
  logic [TW-1:0] now_r, now_nxt;
  logic [TW-1:0] exp_r, exp_nxt;
  logic [HW-1:0] hdl_r, hdl_nxt;
  logic [PW-1:0] pay_r, pay_nxt;
  logic [RW-1:0] cand_r, cand_nxt;
  logic [RW-1:0] pend_e_r, pend_e_nxt;
  logic [ottq_pkg::DELAY_W-1:0] nd_r, nd_nxt;
  logic [ottq_pkg::KIND_W-1:0]  okind_r, okind_nxt;
  logic [HW-1:0] ohdl_r, ohdl_nxt;
  logic [ottq_pkg::PAY_W-1:0] opay_r, opay_nxt;
  logic [ottq_pkg::DELAY_W-1:0] ond_r, ond_nxt;
  logic        olast_r, olast_nxt;

  // RAM port
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [RW-1:0] wdata, rdata;
  logic [TW-1:0] r_exp;
  logic [HW-1:0] r_hdl;
  logic [CW-1:0] idx_m1;

  ottq_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata)
  );

  assign r_exp  = rdata[TW-1:0];
  assign r_hdl  = rdata[RW-1:TW+PW];
  assign idx_m1 = idx_r - 1'b1;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {3'b000, ond_r, opay_r, ohdl_r};

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    pend_nxt   = pend_r;
    fires_nxt  = fires_r;
    ovalid_nxt = ovalid_r && !out_tready;
    op_nxt     = op_r;
    now_nxt    = now_r;
    exp_nxt    = exp_r;
    hdl_nxt    = hdl_r;
    pay_nxt    = pay_r;
    cand_nxt   = cand_r;
    pend_e_nxt = pend_e_r;
    nd_nxt     = nd_r;
    okind_nxt  = okind_r;
    ohdl_nxt   = ohdl_r;
    opay_nxt   = opay_r;
    ond_nxt    = ond_r;
    olast_nxt  = olast_r;
    we    = 1'b0;
    re    = 1'b0;
    waddr = idx_r[AW-1:0];
    raddr = idx_r[AW-1:0];
    wdata = rdata;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt  = in_tuser;
          now_nxt = in_tdata[31:0];
          hdl_nxt = in_tdata[35:32];
          exp_nxt = in_tdata[31:0] + in_tdata[67:36];
          pay_nxt = PW'(in_tdata[99:68]);
          idx_nxt = '0;
          pend_nxt = 1'b0;
          case (in_tuser)
            ottq_pkg::OP_ADD, ottq_pkg::OP_REMOVE: state_nxt = S_RSCAN;
            ottq_pkg::OP_FIRE:                     state_nxt = S_FRD;
            default:                               state_nxt = S_QRD;
          endcase
        end
      end
      // look for the handle
      S_RSCAN: begin
        if (idx_r == count_r) begin
          state_nxt = (op_r == ottq_pkg::OP_ADD) ? S_AFULL : S_IDLE;
        end else begin
          re = 1'b1;
          state_nxt = S_RCHK;
        end
      end
      S_RCHK: begin
        idx_nxt = idx_r + 1'b1;
        state_nxt = (r_hdl == hdl_r) ? S_DSHR : S_RSCAN;
      end
      // close the gap: move entry idx to idx-1
      S_DSHR: begin
        if (idx_r == count_r) begin
          count_nxt = count_r - 1'b1;
          case (op_r)
            ottq_pkg::OP_ADD:  state_nxt = S_AFULL;
            ottq_pkg::OP_FIRE: state_nxt = S_FRD;
            default:           state_nxt = S_IDLE;
          endcase
        end else begin
          re = 1'b1;
          state_nxt = S_DSHW;
        end
      end
      S_DSHW: begin
        we = 1'b1;
        waddr = idx_m1[AW-1:0];
        idx_nxt = idx_r + 1'b1;
        state_nxt = S_DSHR;
      end
      // full check, then search the insert point
      S_AFULL: begin
        if (count_r == DEPTH_C) begin
          if (!ovalid_r) begin
            ovalid_nxt = 1'b1;
            okind_nxt = ottq_pkg::KIND_FULL;
            ohdl_nxt  = hdl_r;
            opay_nxt  = '0;
            ond_nxt   = '0;
            olast_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          idx_nxt = '0;
          state_nxt = S_ASCAN;
        end
      end
      S_ASCAN: begin
        if (idx_r == count_r) begin
          pos_nxt = count_r;
          state_nxt = S_ISHR;
        end else begin
          re = 1'b1;
          state_nxt = S_ACHK;
        end
      end
      S_ACHK: begin
        if (r_exp > exp_r) begin
          pos_nxt = idx_r;
          idx_nxt = count_r;
          state_nxt = S_ISHR;
        end else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_ASCAN;
        end
      end
      // open the gap from the tail, then store the new entry
      S_ISHR: begin
        if (idx_r == pos_r) begin
          we = 1'b1;
          wdata = {hdl_r, pay_r, exp_r};
          count_nxt = count_r + 1'b1;
          state_nxt = S_IDLE;
        end else begin
          re = 1'b1;
          raddr = idx_m1[AW-1:0];
          state_nxt = S_ISHW;
        end
      end
      S_ISHW: begin
        we = 1'b1;
        idx_nxt = idx_m1;
        state_nxt = S_ISHR;
      end
      // fire: peek the head
      S_FRD: begin
        if (count_r == '0) begin
          fires_nxt = 1'b0;
          state_nxt = S_FOUT;
        end else begin
          re = 1'b1;
          raddr = '0;
          state_nxt = S_FCHK;
        end
      end
      S_FCHK: begin
        cand_nxt  = rdata;
        fires_nxt = (r_exp <= now_r);
        state_nxt = S_FOUT;
      end
      // emit the held timer once the next one is known
      S_FOUT: begin
        if (!(pend_r && ovalid_r)) begin
          if (pend_r) begin
            ovalid_nxt = 1'b1;
            okind_nxt = ottq_pkg::KIND_FIRED;
            ohdl_nxt  = pend_e_r[RW-1:TW+PW];
            opay_nxt  = ottq_pkg::PAY_W'(pend_e_r[TW+PW-1:TW]);
            ond_nxt   = '0;
            olast_nxt = !fires_r;
          end
          if (fires_r) begin
            pend_nxt   = 1'b1;
            pend_e_nxt = cand_r;
            idx_nxt    = CW'(1);
            state_nxt  = S_DSHR;
          end else begin
            pend_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end
      // query
      S_QRD: begin
        if (count_r == '0) begin
          nd_nxt = '1;
          state_nxt = S_QOUT;
        end else begin
          re = 1'b1;
          raddr = '0;
          state_nxt = S_QCHK;
        end
      end
      S_QCHK: begin
        nd_nxt = (r_exp > now_r) ? {1'b0, r_exp - now_r} : '0;
        state_nxt = S_QOUT;
      end
      S_QOUT: begin
        if (!ovalid_r) begin
          ovalid_nxt = 1'b1;
          okind_nxt = ottq_pkg::KIND_DELAY;
          ohdl_nxt  = '0;
          opay_nxt  = '0;
          ond_nxt   = nd_r;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      idx_r    <= '0;
      pos_r    <= '0;
      pend_r   <= 1'b0;
      fires_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      idx_r    <= idx_nxt;
      pos_r    <= pos_nxt;
      pend_r   <= pend_nxt;
      fires_r  <= fires_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    now_r    <= now_nxt;
    exp_r    <= exp_nxt;
    hdl_r    <= hdl_nxt;
    pay_r    <= pay_nxt;
    cand_r   <= cand_nxt;
    pend_e_r <= pend_e_nxt;
    nd_r     <= nd_nxt;
    okind_r  <= okind_nxt;
    ohdl_r   <= ohdl_nxt;
    opay_r   <= opay_nxt;
    ond_r    <= ond_nxt;
    olast_r  <= olast_nxt;
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C) else $error("entry count above depth");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> (count_r == $past(count_r) + 1'b1 ||
                                     count_r == $past(count_r) - 1'b1))
    else $error("entry count jumped");
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !we) else $error("RAM write while idle");
  a_kind_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> (okind_r == ottq_pkg::KIND_FIRED || okind_r == ottq_pkg::KIND_DELAY ||
                  okind_r == ottq_pkg::KIND_FULL)) else $error("bad result kind");
endmodule
`default_nettype wire

[test/ordered_timer_queue_unit_test.sv]
// Self-checking testbench for the ordered timer queue: random timer requests, checked results.
`timescale 1ns / 1ps
`default_nettype none

// Sorted timer list kept in the testbench, plus the queue of results it predicts
class timer_list_scoreboard;
  typedef struct packed {
    logic [ottq_pkg::KIND_W-1:0]  kind;
    logic [ottq_pkg::HDL_W-1:0]   handle;
    logic [ottq_pkg::PAY_W-1:0]   payload;
    logic [ottq_pkg::DELAY_W-1:0] delay;
    logic                         last;
  } timer_result_t;

  logic [31:0] expiry_q[$];
  logic [31:0] payload_q[$];
  logic [3:0]  handle_q[$];
  timer_result_t pending_q[$];
  int errors;

  function void drop_handle(logic [3:0] h);
    for (int i = 0; i < handle_q.size(); i++) begin
      if (handle_q[i] == h) begin
        expiry_q.delete(i);
        payload_q.delete(i);
        handle_q.delete(i);
        return;
      end
    end
  endfunction

  function void push_result(logic [1:0] k, logic [3:0] h, logic [31:0] p,
                            logic [32:0] d, logic l);
    timer_result_t r;
    r.kind = k;
    r.handle = h;
    r.payload = p;
    r.delay = d;
    r.last = l;
    pending_q.push_back(r);
  endfunction

  // Update the timer list for one accepted request and queue its results
  function void note_request(logic [1:0] op, logic [31:0] now, logic [3:0] h,
                             logic [31:0] dly, logic [31:0] pay);
    logic [31:0] exp;
    int pos;
    int fired;
    exp = now + dly;
    fired = 0;
    case (op)
      ottq_pkg::OP_ADD: begin
        drop_handle(h);
        if (handle_q.size() >= 16) begin
          push_result(ottq_pkg::KIND_FULL, h, '0, '0, 1'b1);
        end else begin
          pos = 0;
          while (pos < expiry_q.size() && expiry_q[pos] <= exp) pos++;
          expiry_q.insert(pos, exp);
          payload_q.insert(pos, pay);
          handle_q.insert(pos, h);
        end
      end
      ottq_pkg::OP_REMOVE: drop_handle(h);
      ottq_pkg::OP_FIRE: begin
        while (expiry_q.size() > 0 && expiry_q[0] <= now) begin
          push_result(ottq_pkg::KIND_FIRED, handle_q[0], payload_q[0], '0, 1'b0);
          expiry_q.pop_front();
          payload_q.pop_front();
          handle_q.pop_front();
          fired++;
        end
        if (fired > 0) pending_q[pending_q.size() - 1].last = 1'b1;
      end
      default: begin
        if (expiry_q.size() == 0)
          push_result(ottq_pkg::KIND_DELAY, '0, '0, '1, 1'b1);
        else if (now >= expiry_q[0])
          push_result(ottq_pkg::KIND_DELAY, '0, '0, '0, 1'b1);
        else
          push_result(ottq_pkg::KIND_DELAY, '0, '0, {1'b0, expiry_q[0] - now}, 1'b1);
      end
    endcase
  endfunction

  task report_mismatch(string what, logic [32:0] got, logic [32:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // Compare one accepted result with the oldest prediction
  task check_result(logic [1:0] kind, logic [71:0] data, logic last);
    timer_result_t w;
    if (pending_q.size() == 0) begin
      report_mismatch("unexpected result", 33'(kind), '0);
      return;
    end
    w = pending_q.pop_front();
    if (kind != w.kind) report_mismatch("kind", 33'(kind), 33'(w.kind));
    if (data[3:0] != w.handle) report_mismatch("handle", 33'(data[3:0]), 33'(w.handle));
    if (data[35:4] != w.payload)
      report_mismatch("payload", 33'(data[35:4]), 33'(w.payload));
    if (data[68:36] != w.delay) report_mismatch("delay", data[68:36], w.delay);
    if (last != w.last) report_mismatch("last", 33'(last), 33'(w.last));
  endtask
endclass

module ordered_timer_queue_unit_test;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [ottq_pkg::OP_W-1:0] in_tuser = '0;
  logic [ottq_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [ottq_pkg::KIND_W-1:0] out_tuser;
  logic [ottq_pkg::OUT_DATA_W-1:0] out_tdata;
  logic out_tlast;

  timer_list_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;
  int cycle_count = 0;
  logic [31:0] now_tick = 32'd1000;

  ordered_timer_queue_unit u_dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // Receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tuser, out_tdata, out_tlast);
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("ordered_timer_queue_unit verification failed");
      $finish;
    end
  end

  // Offer one request, wait for acceptance, then idle at random
  task automatic send_request(logic [1:0] op, logic [31:0] now, logic [3:0] h,
                              logic [31:0] dly, logic [31:0] pay);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {4'd0, pay, dly, h, now};
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, now, h, dly, pay);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.pending_q.size() > 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // Mostly well-formed traffic: time moves forward with rare jumps; adds, removes, fires, queries
  task automatic random_request();
    int r;
    logic [31:0] dly;
    r = $urandom_range(99);
    now_tick = now_tick + $urandom_range(40);
    if ($urandom_range(19) == 0) now_tick = $urandom;
    dly = ($urandom_range(9) == 0) ? $urandom : $urandom_range(120);
    if (r < 45)
      send_request(ottq_pkg::OP_ADD, now_tick, 4'($urandom), dly, $urandom);
    else if (r < 60)
      send_request(ottq_pkg::OP_REMOVE, now_tick, 4'($urandom), $urandom, $urandom);
    else if (r < 82)
      send_request(ottq_pkg::OP_FIRE, now_tick, 4'($urandom), $urandom, $urandom);
    else
      send_request(ottq_pkg::OP_QUERY, now_tick, 4'($urandom), $urandom, $urandom);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty queue cases, extremes, equal expiries, full queue
    send_request(ottq_pkg::OP_QUERY, 32'd0, 4'd0, 32'd0, 32'd0);
    send_request(ottq_pkg::OP_FIRE, 32'hFFFF_FFFF, 4'd0, 32'd0, 32'd0);
    send_request(ottq_pkg::OP_REMOVE, 32'd5, 4'd9, 32'd0, 32'd0);
    send_request(ottq_pkg::OP_ADD, 32'hFFFF_FFF0, 4'd15, 32'h20, 32'hFFFF_FFFF);
    send_request(ottq_pkg::OP_ADD, 32'd0, 4'd3, 32'hFFFF_FFFF, 32'h0);
    send_request(ottq_pkg::OP_ADD, 32'd10, 4'd4, 32'd10, 32'hA5A5_5A5A);
    send_request(ottq_pkg::OP_ADD, 32'd10, 4'd5, 32'd10, 32'h5A5A_A5A5);
    send_request(ottq_pkg::OP_ADD, 32'd12, 4'd4, 32'd50, 32'h1234_5678);
    send_request(ottq_pkg::OP_QUERY, 32'd15, 4'd0, 32'd0, 32'd0);
    send_request(ottq_pkg::OP_QUERY, 32'd100, 4'd0, 32'd0, 32'd0);
    send_request(ottq_pkg::OP_REMOVE, 32'd20, 4'd3, 32'd0, 32'd0);
    send_request(ottq_pkg::OP_FIRE, 32'd20, 4'd0, 32'd0, 32'd0);
    for (int i = 0; i < 16; i++)
      send_request(ottq_pkg::OP_ADD, 32'd30, i[3:0], 32'd5, {28'hF0F0F0F, i[3:0]});
    send_request(ottq_pkg::OP_ADD, 32'd30, 4'd7, 32'd1, 32'hDEAD_BEEF);
    send_request(ottq_pkg::OP_FIRE, 32'hFFFF_FFFF, 4'd0, 32'd0, 32'd0);
    drain_results();

    // Random phases across idle/stall settings
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 61 : 34) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 61 : 34) : 0;
      if (ph == 2) hold_off_cycles = 600;
      for (int n = 0; n < 95; n++) random_request();
      drain_results();
    end

    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("ordered_timer_queue_unit verification clean");
    else
      $display("ordered_timer_queue_unit verification failed");
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
rtl/core/ottq_pkg.sv
rtl/core/ottq_ram.sv
rtl/core/ordered_timer_queue_unit.sv
test/ordered_timer_queue_unit_test.sv
